// ===== rtl/tbd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register codes and constants for the tile box downsampler.
// No dependencies; used by tbd_accum, tbd_div and tile_box_downsampler.
package tbd_pkg;

  // Parameter defaults
  localparam int MaxTileDef     = 512;
  localparam int MaxChannelsDef = 4;
  localparam int SampleBitsDef  = 32;

  // Fixed field and register widths
  localparam int FieldBits     = 32;
  localparam int CfgIndexBits  = 2;
  localparam int CfgDataBits   = 10;
  localparam int FactorBits    = 4;
  localparam int SppBits       = 3;
  localparam int TileWidthBits = 10;
  localparam int FactorMax     = 8;
  localparam int ExtraSumBits  = 6;   // up to 64 samples in one block sum
  localparam int DivRadixBits  = 4;   // quotient bits per divider cycle

  // Register reset values
  localparam logic [FactorBits-1:0]    FactorReset    = 4'd2;
  localparam logic                     AvgModeReset   = 1'b1;
  localparam logic [SppBits-1:0]       SppReset       = 3'd3;
  localparam logic [TileWidthBits-1:0] TileWidthReset = 10'd512;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_FACTOR     = 2'd0,
    CFG_AVG_MODE   = 2'd1,
    CFG_SPP        = 2'd2,
    CFG_TILE_WIDTH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [FieldBits-1:0] sample;
    logic                 tile_start;
  } item_t;

  typedef struct packed {
    logic [FieldBits-1:0] value;
    logic [1:0]           channel;
    logic                 tile_done;
  } result_t;

  // Per-sample control from the position sequencer to the accumulator
  typedef struct packed {
    logic en;         // sample lies inside a whole block
    logic col_start;  // first column of its block
    logic col_end;    // last column of its block
    logic row_start;  // first row of its block
    logic row_end;    // last row of its block
    logic tile_done;  // last result of the reduced tile
  } acc_ctl_t;

  typedef struct packed {
    logic [1:0] channel;
    logic       tile_done;
  } div_tag_t;

  typedef struct packed {
    logic idle;
    logic running;
  } div_status_t;

  function automatic logic [6:0] factor_sq(input logic [FactorBits-1:0] f);
    logic [6:0] f7;
    f7 = {3'b000, f};
    return 7'(f7 * f7);
  endfunction

endpackage

// ===== rtl/tile_box_downsampler.sv =====
`timescale 1ns / 1ps
// Tile box downsampler top level: configuration registers, position
// sequencer and transfer control. Depends on tbd_pkg, tbd_accum, tbd_div.
//
// Usage:
//   item channel (item_valid/item_stall/item) takes one channel sample per
//   transfer, interleaved channels in raster order; tile_start restarts the
//   position at the tile origin. result channel (result_valid/result_stall/
//   result) gives one reduced sample per finished block and channel.
//   Configuration is written through cfg_en/cfg_index/cfg_data while idle;
//   every write restarts the position at the origin.
// Throughput: with the divider free a sample is taken every cycle. A sample
//   that completes a block stalls the input for the column-sum
//   read-modify-write and, in average mode, while the 4-bit-a-cycle divider
//   runs. A further block-completing sample also waits for the output
//   register to empty.
// A result passes the column-sum read stage and the divider's state, and in
//   average mode its divide steps, before it is offered.
// Reset (synchronous, rst high) loads the register defaults and clears the
//   position; the column-sum memory is not cleared, every entry is written
//   before its read data is used. While the receiver stalls, a finished result
//   waits in the output register; samples completing no block are still taken.
module tile_box_downsampler import tbd_pkg::*; #(
  parameter int MAX_TILE     = MaxTileDef,
  parameter int MAX_CHANNELS = MaxChannelsDef,
  parameter int SAMPLE_BITS  = SampleBitsDef
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_en,
  input  logic [CfgIndexBits-1:0] cfg_index,
  input  logic [CfgDataBits-1:0]  cfg_data,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  item_t                   item,
  output logic                    result_valid,
  input  logic                    result_stall,
  output result_t                 result
);

  localparam int SUM_BITS = SAMPLE_BITS + ExtraSumBits;
  localparam int PW       = $clog2(MAX_TILE);
  localparam int TWB      = $clog2(MAX_TILE + 1);
  localparam int XW       = TWB + 4;
  localparam int CMPW     = (TWB > TileWidthBits) ? TWB : TileWidthBits;
  localparam int AW       = $clog2(MAX_TILE * MAX_CHANNELS);
  localparam int CHW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Configuration registers
  logic [FactorBits-1:0]    factor;
  logic                     average_mode;
  logic [SppBits-1:0]       samples_per_pixel;
  logic [TileWidthBits-1:0] tile_width;

  // Position state
  logic [PW-1:0]  pos_x, pos_y, bx, by, xb, yb;
  logic [2:0]     rx, ry;
  logic [CHW-1:0] pos_channel;

  logic [PW-1:0]  pos_x_next, pos_y_next, bx_next, by_next, xb_next, yb_next;
  logic [2:0]     rx_next, ry_next;
  logic [CHW-1:0] pos_channel_next;

  logic [PW-1:0]  cur_x, cur_y, cur_bx, cur_by, cur_xb, cur_yb;
  logic [2:0]     cur_rx, cur_ry;
  logic [CHW-1:0] cur_ch;

  logic [FactorBits-1:0] f_eff;
  logic [3:0]            spp_eff;
  logic [TWB-1:0]        tw_eff;
  logic [CMPW-1:0]       tw_wide;
  logic [2:0]            f_last;

  logic        accept;
  logic        inb_cur, inb_reg, last_blk;
  logic        ch_last, x_last, y_last;
  logic        pred;
  acc_ctl_t    ctl;
  logic [AW-1:0] idx;

  logic                acc_busy;
  logic                req_valid;
  logic [SUM_BITS-1:0] req_sum;
  div_tag_t            req_tag;
  div_status_t         div_st;

  // Effective register values
  always_comb begin
    if (factor == '0) begin
      f_eff = FactorBits'(1);
    end else if (factor > FactorBits'(FactorMax)) begin
      f_eff = FactorBits'(FactorMax);
    end else begin
      f_eff = factor;
    end

    if (samples_per_pixel == '0) begin
      spp_eff = 4'd1;
    end else if ({1'b0, samples_per_pixel} > 4'(MAX_CHANNELS)) begin
      spp_eff = 4'(MAX_CHANNELS);
    end else begin
      spp_eff = {1'b0, samples_per_pixel};
    end

    tw_wide = CMPW'(tile_width);
    if (tw_wide == '0) begin
      tw_eff = TWB'(1);
    end else if (tw_wide > CMPW'(MAX_TILE)) begin
      tw_eff = TWB'(MAX_TILE);
    end else begin
      tw_eff = TWB'(tw_wide);
    end
  end

  assign f_last = 3'(f_eff - FactorBits'(1));

  assign accept     = item_valid && !item_stall;

  // A block-completing sample needs the divider free; position at the
  // origin completes a block whenever the factor is one.
  assign inb_reg = (XW'(xb) + XW'(f_eff) <= XW'(tw_eff)) &&
                   (XW'(yb) + XW'(f_eff) <= XW'(tw_eff));
  assign pred    = (inb_reg && (rx == f_last) && (ry == f_last)) ||
                   (f_eff == FactorBits'(1));
  assign item_stall = acc_busy || div_st.running || (!div_st.idle && pred);

  // Position of the sample on the input
  always_comb begin
    if (item.tile_start) begin
      cur_x = '0; cur_y = '0; cur_bx = '0; cur_by = '0;
      cur_xb = '0; cur_yb = '0; cur_rx = '0; cur_ry = '0; cur_ch = '0;
    end else begin
      cur_x = pos_x; cur_y = pos_y; cur_bx = bx; cur_by = by;
      cur_xb = xb; cur_yb = yb; cur_rx = rx; cur_ry = ry; cur_ch = pos_channel;
    end
  end

  assign inb_cur  = (XW'(cur_xb) + XW'(f_eff) <= XW'(tw_eff)) &&
                    (XW'(cur_yb) + XW'(f_eff) <= XW'(tw_eff));
  assign last_blk = (XW'(cur_xb) + XW'({f_eff, 1'b0}) > XW'(tw_eff)) &&
                    (XW'(cur_yb) + XW'({f_eff, 1'b0}) > XW'(tw_eff));

  assign ch_last = (4'(cur_ch) + 4'd1) >= spp_eff;
  assign x_last  = (TWB'(cur_x) + TWB'(1)) >= tw_eff;
  assign y_last  = (TWB'(cur_y) + TWB'(1)) >= tw_eff;

  always_comb begin
    ctl.en        = accept && inb_cur;
    ctl.col_start = (cur_rx == 3'd0);
    ctl.col_end   = (cur_rx == f_last);
    ctl.row_start = (cur_ry == 3'd0);
    ctl.row_end   = (cur_ry == f_last);
    ctl.tile_done = last_blk && ((4'(cur_ch) + 4'd1) == spp_eff);
  end

  assign idx = AW'(int'(cur_bx) * MAX_CHANNELS + int'(cur_ch));

  // Advance by one sample: channel, then column, then row
  always_comb begin
    pos_x_next = cur_x; pos_y_next = cur_y; bx_next = cur_bx; by_next = cur_by;
    xb_next = cur_xb; yb_next = cur_yb; rx_next = cur_rx; ry_next = cur_ry;
    pos_channel_next = cur_ch + CHW'(1);
    if (ch_last) begin
      pos_channel_next = '0;
      if (x_last) begin
        pos_x_next = '0; bx_next = '0; xb_next = '0; rx_next = '0;
        if (y_last) begin
          pos_y_next = '0; by_next = '0; yb_next = '0; ry_next = '0;
        end else begin
          pos_y_next = cur_y + PW'(1);
          if (cur_ry == f_last) begin
            ry_next = '0;
            by_next = cur_by + PW'(1);
            yb_next = cur_yb + PW'(f_eff);
          end else begin
            ry_next = cur_ry + 3'd1;
          end
        end
      end else begin
        pos_x_next = cur_x + PW'(1);
        if (cur_rx == f_last) begin
          rx_next = '0;
          bx_next = cur_bx + PW'(1);
          xb_next = cur_xb + PW'(f_eff);
        end else begin
          rx_next = cur_rx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      factor            <= FactorReset;
      average_mode      <= AvgModeReset;
      samples_per_pixel <= SppReset;
      tile_width        <= TileWidthReset;
      pos_x <= '0; pos_y <= '0; bx <= '0; by <= '0;
      xb <= '0; yb <= '0; rx <= '0; ry <= '0; pos_channel <= '0;
    end else if (cfg_en) begin
      unique case (cfg_index)
        CFG_FACTOR:     factor            <= cfg_data[FactorBits-1:0];
        CFG_AVG_MODE:   average_mode      <= cfg_data[0];
        CFG_SPP:        samples_per_pixel <= cfg_data[SppBits-1:0];
        CFG_TILE_WIDTH: tile_width        <= cfg_data[TileWidthBits-1:0];
      endcase
      pos_x <= '0; pos_y <= '0; bx <= '0; by <= '0;
      xb <= '0; yb <= '0; rx <= '0; ry <= '0; pos_channel <= '0;
    end else if (accept) begin
      pos_x <= pos_x_next; pos_y <= pos_y_next; bx <= bx_next; by <= by_next;
      xb <= xb_next; yb <= yb_next; rx <= rx_next; ry <= ry_next;
      pos_channel <= pos_channel_next;
    end
  end

  tbd_accum #(
    .MAX_TILE     (MAX_TILE),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .avg       (average_mode),
    .ctl       (ctl),
    .idx       (idx),
    .ch        (cur_ch),
    .sample    (item.sample[SAMPLE_BITS-1:0]),
    .busy      (acc_busy),
    .req_valid (req_valid),
    .req_sum   (req_sum),
    .req_tag   (req_tag)
  );

  tbd_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_sum      (req_sum),
    .req_tag      (req_tag),
    .factor       (f_eff),
    .bypass       (!average_mode),
    .status       (div_st),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/tbd_accum.sv =====
`timescale 1ns / 1ps
// Row and column accumulation: per-channel horizontal sums in flops and the
// block column sums in a registered-read synchronous memory. Depends on tbd_pkg.
module tbd_accum import tbd_pkg::*; #(
  parameter int MAX_TILE     = MaxTileDef,
  parameter int MAX_CHANNELS = MaxChannelsDef,
  parameter int SAMPLE_BITS  = SampleBitsDef,
  localparam int SUM_BITS    = SAMPLE_BITS + ExtraSumBits,
  localparam int AW          = $clog2(MAX_TILE * MAX_CHANNELS),
  localparam int CHW         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   avg,
  input  acc_ctl_t               ctl,
  input  logic [AW-1:0]          idx,
  input  logic [CHW-1:0]         ch,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   busy,
  output logic                   req_valid,
  output logic [SUM_BITS-1:0]    req_sum,
  output div_tag_t               req_tag
);

  localparam int DEPTH = MAX_TILE * MAX_CHANNELS;

  logic [SUM_BITS-1:0] hsum [MAX_CHANNELS];
  logic [SUM_BITS-1:0] col_mem [DEPTH];

  logic [SUM_BITS-1:0] h;
  logic [SUM_BITS-1:0] rd_data;
  logic [SUM_BITS-1:0] fwd_data;
  logic                fwd_hit;
  logic                b_valid;
  logic                b_first;
  logic                b_res;
  logic [SUM_BITS-1:0] b_h;
  logic [AW-1:0]       b_idx;
  div_tag_t            b_tag;
  logic [SUM_BITS-1:0] old_sum;
  logic [SUM_BITS-1:0] c;
  logic                rd_en;

  assign rd_en = ctl.en && ctl.col_end;

  always_comb begin
    if (ctl.col_start) begin
      h = SUM_BITS'(sample);
    end else if (avg) begin
      h = hsum[ch] + SUM_BITS'(sample);
    end else begin
      h = hsum[ch];
    end
  end

  // Write-back of the previous sample lands on the edge of this read
  assign old_sum = fwd_hit ? fwd_data : rd_data;

  always_comb begin
    if (b_first) begin
      c = b_h;
    end else if (avg) begin
      c = old_sum + b_h;
    end else begin
      c = old_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      hsum[ch] <= h;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= col_mem[idx];
    end
    if (b_valid) begin
      col_mem[b_idx] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      b_valid <= rd_en;
      fwd_hit <= rd_en && b_valid && (idx == b_idx);
    end
    fwd_data <= c;
    if (rd_en) begin
      b_h             <= h;
      b_idx           <= idx;
      b_first         <= ctl.row_start;
      b_res           <= ctl.row_end;
      b_tag.channel   <= 2'(ch);
      b_tag.tile_done <= ctl.tile_done;
    end
  end

  assign busy      = b_valid && b_res;
  assign req_valid = b_valid && b_res;
  assign req_sum   = c;
  assign req_tag   = b_tag;

endmodule

// ===== rtl/tbd_div.sv =====
`timescale 1ns / 1ps
// Iterative divide of a block sum by factor squared, DivRadixBits quotient
// bits a cycle (skipped in bypass), with the result output register. Depends on tbd_pkg.
module tbd_div import tbd_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDef,
  localparam int SUM_BITS   = SAMPLE_BITS + ExtraSumBits
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic [SUM_BITS-1:0]   req_sum,
  input  div_tag_t              req_tag,
  input  logic [FactorBits-1:0] factor,
  input  logic                  bypass,
  output div_status_t           status,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  localparam int STEPS = (SUM_BITS + DivRadixBits - 1) / DivRadixBits;
  localparam int DW    = STEPS * DivRadixBits;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DONE
  } state_t;

  state_t         state;
  logic [DW-1:0]  work;
  logic [5:0]     rem;
  logic [6:0]     divisor;
  logic [CW-1:0]  cnt;
  div_tag_t       tag;
  logic [DW-1:0]  work_next;
  logic [5:0]     rem_next;

  // Restoring division, remainder stays below divisor (at most 64)
  always_comb begin
    logic [6:0] t7;
    work_next = work;
    rem_next  = rem;
    for (int i = 0; i < DivRadixBits; i++) begin
      t7        = {rem_next, work_next[DW-1]};
      work_next = {work_next[DW-2:0], 1'b0};
      if (t7 >= divisor) begin
        t7           = t7 - divisor;
        work_next[0] = 1'b1;
      end
      rem_next = t7[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            work    <= DW'(req_sum);
            rem     <= '0;
            divisor <= factor_sq(factor);
            tag     <= req_tag;
            cnt     <= CW'(STEPS - 1);
            state   <= bypass ? DONE : RUN;
          end
        end
        RUN: begin
          work <= work_next;
          rem  <= rem_next;
          cnt  <= cnt - CW'(1);
          if (cnt == '0) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!result_stall) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign status.idle      = (state == IDLE);
  assign status.running   = (state == RUN);
  assign result_valid     = (state == DONE);
  assign result.value     = FieldBits'(work[SAMPLE_BITS-1:0]);
  assign result.channel   = tag.channel;
  assign result.tile_done = tag.tile_done;

endmodule

// ===== tb/tile_box_downsampler_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for tile_box_downsampler: directed and random tiles,
// with a software predictor of the block sums. Depends on tbd_pkg and the RTL.
module tile_box_downsampler_test;
  import tbd_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_en = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0]  cfg_data = '0;
  logic                    item_valid = 1'b0;
  logic                    item_stall;
  item_t                   item = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  result_t                 result;

  tile_box_downsampler u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_en       (cfg_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #1 clk = ~clk;

  // Predictor copy of registers and accumulator state
  logic [FactorBits-1:0]    cfg_factor;
  logic                     cfg_avg;
  logic [SppBits-1:0]       cfg_spp;
  logic [TileWidthBits-1:0] cfg_width;
  logic [37:0]              col_acc [MaxTileDef*MaxChannelsDef];
  logic [37:0]              row_acc [MaxChannelsDef];
  logic [8:0]               pos_x, pos_y;
  logic [1:0]               pos_ch;

  item_t       pending_samples [$];
  result_t     expected_results [$];
  result_t     predicted;
  result_t     want;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_no = 0;
  int unsigned hold_left = 0;
  int unsigned queued_total = 0;
  bit          hold_used = 0;
  logic        quiet;

  // no idling on either side in this window
  assign quiet = (cycle_no >= 800) && (cycle_no < 2000);

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic bit downsample_predict(input item_t it, output result_t res);
    int unsigned f, spp, tw, ds, bx, by, rx, ry, ch, idx, nx, ny, nch;
    logic [37:0] h, c, q;
    bit hit;
    hit = 0;
    res = '0;
    f   = clampu(cfg_factor, 1, FactorMax);
    spp = clampu(cfg_spp, 1, MaxChannelsDef);
    tw  = clampu(cfg_width, 1, MaxTileDef);
    if (it.tile_start || pos_ch >= spp || pos_x >= tw || pos_y >= tw) begin
      pos_x = '0;
      pos_y = '0;
      pos_ch = '0;
    end
    ch = pos_ch;
    ds = tw / f;
    bx = pos_x / f;
    rx = pos_x % f;
    by = pos_y / f;
    ry = pos_y % f;
    if (bx < ds && by < ds) begin
      h = row_acc[ch];
      if (rx == 0) h = {6'd0, it.sample};
      else if (cfg_avg) h = h + {6'd0, it.sample};
      row_acc[ch] = h;
      if (rx == f - 1) begin
        idx = bx * MaxChannelsDef + ch;
        c = col_acc[idx];
        if (ry == 0) c = h;
        else if (cfg_avg) c = c + h;
        col_acc[idx] = c;
        if (ry == f - 1) begin
          q = cfg_avg ? c / 38'(f * f) : c;
          res.value = q[31:0];
          res.channel = ch[1:0];
          res.tile_done = (bx == ds - 1) && (by == ds - 1) && (ch == spp - 1);
          hit = 1;
        end
      end
    end
    nch = ch + 1;
    if (nch >= spp) begin
      nch = 0;
      nx = pos_x + 1;
      if (nx >= tw) begin
        nx = 0;
        ny = pos_y + 1;
        if (ny >= tw) ny = 0;
        pos_y = ny[8:0];
      end
      pos_x = nx[8:0];
    end
    pos_ch = nch[1:0];
    return hit;
  endfunction

  // Driver: offers queued samples, predicts on each transfer
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        if (downsample_predict(item, predicted)) begin
          expected_results.insert(expected_results.size(), predicted);
        end
      end
      if (!item_valid || !item_stall) begin
        if (pending_samples.size() != 0 && (quiet || $urandom_range(99) >= 26)) begin
          item <= pending_samples.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and drives stall
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: value %h channel %0d tile_done %0b",
                   $time, result.value, result.channel, result.tile_done);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (result !== want) begin
            $display("%0t: expected value %h channel %0d tile_done %0b, got %h %0d %0b",
                     $time, want.value, want.channel, want.tile_done,
                     result.value, result.channel, result.tile_done);
            mismatches++;
          end
        end
      end
      // one long hold-off so the output fills and the input backs up
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (!hold_used && results_seen >= 8 && pending_samples.size() > 50) begin
        hold_used = 1;
        hold_left = 300;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !quiet && ($urandom_range(99) < 26);
      end
    end
  end

  task automatic wait_idle();
    while (pending_samples.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataBits-1:0] data);
    @(posedge clk);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_en <= 1'b0;
    case (idx)
      CFG_FACTOR:     cfg_factor = data[FactorBits-1:0];
      CFG_AVG_MODE:   cfg_avg = data[0];
      CFG_SPP:        cfg_spp = data[SppBits-1:0];
      CFG_TILE_WIDTH: cfg_width = data[TileWidthBits-1:0];
      default: ;
    endcase
    pos_x = '0;
    pos_y = '0;
    pos_ch = '0;
  endtask

  // unused upper data bits are filled at random; the block masks them
  task automatic configure(input logic [3:0] f, input logic avg, input logic [2:0] spp,
                           input logic [9:0] tw);
    wait_idle();
    write_reg(CFG_FACTOR, {6'($urandom), f});
    write_reg(CFG_AVG_MODE, {9'($urandom), avg});
    write_reg(CFG_SPP, {7'($urandom), spp});
    write_reg(CFG_TILE_WIDTH, tw);
  endtask

  function automatic logic [31:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return 32'hFFFF_FFFF;
    if (pick < 15) return 32'h0;
    return $urandom;
  endfunction

  task automatic push_samples(input int unsigned n, input bit first_start,
                              input bit stray_starts);
    item_t it;
    for (int unsigned i = 0; i < n; i++) begin
      it.sample = rand_sample();
      it.tile_start = (i == 0) ? first_start : (stray_starts && $urandom_range(19) == 0);
      pending_samples.insert(pending_samples.size(), it);
      queued_total++;
    end
  endtask

  task automatic push_fixed(input logic [31:0] s, input int unsigned n, input bit first_start);
    item_t it;
    for (int unsigned i = 0; i < n; i++) begin
      it.sample = s;
      it.tile_start = (i == 0) && first_start;
      pending_samples.insert(pending_samples.size(), it);
      queued_total++;
    end
  endtask

  initial begin : stimulus
    int unsigned f_eff, spp_eff, tw_eff, full, n, kind, tiles;
    logic [3:0]  f;
    logic [2:0]  spp;
    logic [9:0]  tw;
    logic        avg;
    cfg_factor = FactorReset;
    cfg_avg = AvgModeReset;
    cfg_spp = SppReset;
    cfg_width = TileWidthReset;
    for (int i = 0; i < MaxChannelsDef; i++) row_acc[i] = '0;
    for (int i = 0; i < MaxTileDef*MaxChannelsDef; i++) col_acc[i] = '0;
    pos_x = '0;
    pos_y = '0;
    pos_ch = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // factor 0 and channels 0 act as 1, oversize width clamps: every sample passes
    configure(4'd0, 1'b1, 3'd0, 10'd1023);
    push_fixed(32'h0, 1, 1'b1);
    push_fixed(32'hFFFF_FFFF, 1, 1'b0);
    push_fixed(32'h5555_5555, 1, 1'b0);
    push_fixed(32'hAAAA_AAAA, 1, 1'b1);
    // 2x2 average: restart mid-tile, all-ones block, then wrap into a zero tile
    configure(4'd2, 1'b1, 3'd1, 10'd2);
    push_fixed(32'h1234_5678, 2, 1'b0);
    push_fixed(32'hFFFF_FFFF, 4, 1'b1);
    push_fixed(32'h0, 4, 1'b0);
    // nearest mode keeps the top-left sample
    configure(4'd2, 1'b0, 3'd1, 10'd2);
    push_samples(4, 1'b1, 1'b0);
    // factor larger than the tile: no results
    configure(4'd4, 1'b0, 3'd1, 10'd3);
    push_samples(4, 1'b1, 1'b0);
    // largest block and most channels, all ones for the widest sums
    configure(4'd15, 1'b1, 3'd7, 10'd8);
    push_fixed(32'hFFFF_FFFF, 256, 1'b1);
    // one result per sample; the long hold-off lands here
    configure(4'd1, 1'b0, 3'd2, 10'd8);
    push_samples(128, 1'b1, 1'b0);

    while (queued_total < 700) begin
      f = ($urandom_range(99) < 75) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(0, 15));
      avg = $urandom_range(1);
      spp = ($urandom_range(99) < 85) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
      if ($urandom_range(99) < 90) tw = 10'($urandom_range(1, 10));
      else tw = $urandom_range(1) ? 10'd0 : 10'($urandom_range(11, 1023));
      configure(f, avg, spp, tw);
      f_eff = clampu(f, 1, FactorMax);
      spp_eff = clampu(spp, 1, MaxChannelsDef);
      tw_eff = clampu(tw, 1, MaxTileDef);
      full = tw_eff * tw_eff * spp_eff;
      if (full > 300) full = $urandom_range(20, 120);
      tiles = $urandom_range(1, 3);
      for (int unsigned t = 0; t < tiles; t++) begin
        if (queued_total >= 700) break;
        kind = $urandom_range(99);
        if (kind < 80) n = full;
        else if (kind < 90) n = $urandom_range(1, full);
        else n = full;
        if (n > 700 - queued_total) n = 700 - queued_total;
        push_samples(n, kind < 95, kind >= 90 && kind < 95);
      end
    end

    wait_idle();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tbd_pkg.sv
rtl/tbd_accum.sv
rtl/tbd_div.sv
rtl/tile_box_downsampler.sv
tb/tile_box_downsampler_test.sv
